### hdl/afd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_pkg: shared types and codes of the address allow/deny filter
// Operation and status codes, field widths and the control and status
// structures passed between the controller, the lists and their cells.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam int ADDR_W  = 48;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_PRESENT   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd3;

    localparam logic LIST_ALLOW = 1'b0;
    localparam logic LIST_DENY  = 1'b1;

    typedef struct packed {
        logic compare;
        logic sweep;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic compare;
        logic sweep;
        logic add;
        logic remove;
    } list_ctrl_t;

    typedef struct packed {
        logic               found;
        logic               full;
        logic               empty_next;
        logic [COUNT_W-1:0] count_next;
    } list_stat_t;

endpackage

### hdl/afd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_cell: one entry of an address list
// Holds one address and a match flag that ripples to the next cell, one cell
// per cycle. On a removal each flagged cell takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module afd_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  afd_pkg::cell_ctrl_t          ctrl,
    input  logic [afd_pkg::ADDR_W-1:0]   addr,
    input  logic                         in_use,
    input  logic                         write_en,
    input  logic                         kill_in,
    input  logic [afd_pkg::ADDR_W-1:0]   next_entry,
    output logic [afd_pkg::ADDR_W-1:0]   entry,
    output logic                         kill
);

    logic [afd_pkg::ADDR_W-1:0] entry_reg;
    logic                       kill_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift && kill_reg)
        begin
            entry_reg <= next_entry;
        end
        else if (write_en)
        begin
            entry_reg <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            kill_reg <= in_use && (entry_reg == addr);
        end
        else if (ctrl.sweep)
        begin
            kill_reg <= kill_reg | kill_in;
        end
    end

    assign entry = entry_reg;
    assign kill  = kill_reg;

endmodule

### hdl/afd_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afd_list: one order-preserving address list
// A row of cells with a fill count. The match flags sweep along the row; the
// last cell then tells whether the address is present, and the flagged cells
// close the gap of the first match on a removal.
// ----------------------------------------------------------------------------
module afd_list
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  afd_pkg::list_ctrl_t        ctrl,
    input  logic [afd_pkg::ADDR_W-1:0] addr,
    output afd_pkg::list_stat_t        stat
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0]           used_reg;
    logic [CNT_W-1:0]           used_next;
    logic [CNT_W+4:0]           used_ext;
    logic                       found;
    logic                       full;
    logic                       do_add;
    logic                       do_remove;
    afd_pkg::cell_ctrl_t        cell_ctrl;
    logic [afd_pkg::ADDR_W-1:0] entries [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     kills;

    assign found     = kills[MAX_ENTRIES-1];
    assign full      = (used_reg == CNT_W'(MAX_ENTRIES));
    assign do_add    = ctrl.add && !full && !found;
    assign do_remove = ctrl.remove && found;

    assign cell_ctrl.compare = ctrl.compare;
    assign cell_ctrl.sweep   = ctrl.sweep;
    assign cell_ctrl.shift   = do_remove;

    generate
        for (genvar i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            logic                       kill_in;
            logic [afd_pkg::ADDR_W-1:0] next_entry;

            if (i == 0)
            begin : g_first
                assign kill_in = 1'b0;
            end
            else
            begin : g_inner
                assign kill_in = kills[i-1];
            end

            if (i == MAX_ENTRIES - 1)
            begin : g_last
                assign next_entry = entries[i];
            end
            else
            begin : g_body
                assign next_entry = entries[i+1];
            end

            afd_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .addr       (addr),
                .in_use     (CNT_W'(i) < used_reg),
                .write_en   (do_add && (used_reg == CNT_W'(i))),
                .kill_in    (kill_in),
                .next_entry (next_entry),
                .entry      (entries[i]),
                .kill       (kills[i])
            );
        end
    endgenerate

    always_comb
    begin
        used_next = used_reg;
        if (do_add)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            used_next = used_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign used_ext        = {5'b0, used_next};
    assign stat.found      = found;
    assign stat.full       = full;
    assign stat.empty_next = (used_next == '0);
    assign stat.count_next = used_ext[afd_pkg::COUNT_W-1:0];

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_ENTRIES))
        else $error("List count exceeds its capacity.");

    a_add_remove_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.add && ctrl.remove))
        else $error("Add and remove were issued in the same cycle.");

    a_remove_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |-> (used_reg != '0))
        else $error("A match was flagged in an empty list.");
`endif

endmodule

### hdl/address_allow_deny_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_allow_deny_filter_core: allow/deny list filter for device addresses
// Runs queries, adds and removes against an allow list and a deny list.
//
// Channel  Direction  Transfer contents
// s_axis   in         tdata: op, device_address; tuser: list_select
// m_axis   out        tdata: success, status, allowed, in_deny_list,
//                     in_allow_list, allow_count, deny_count
//
// An item passes from acceptance through a compare state, a sweep state in
// which the match flag ripples along the cell rows, and an update state
// that writes its result. One item is processed at a time; the next
// one is taken while the previous result waits in the output register.
// The update cycle waits while that register is still full. Reset empties
// both lists at once.
// ----------------------------------------------------------------------------
module address_allow_deny_filter_core
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op[1:0], device_address[49:2], zero[55:50]
    input  logic        s_tuser,   // list_select[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // success[0], status[2:1], allowed[3],
                                   // in_deny_list[4], in_allow_list[5],
                                   // allow_count[10:6], deny_count[15:11]
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_SWEEP   = 2'd2;
    localparam logic [1:0] ST_UPDATE  = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [CNT_W-1:0]             sweep_cnt_reg;
    logic [afd_pkg::OP_W-1:0]     op_reg;
    logic [afd_pkg::ADDR_W-1:0]   addr_reg;
    logic                         sel_reg;
    logic                         out_valid_reg;
    logic [15:0]                  out_data_reg;
    logic                         upd_go;
    logic                         accept;
    afd_pkg::list_ctrl_t          allow_ctrl;
    afd_pkg::list_ctrl_t          deny_ctrl;
    afd_pkg::list_stat_t          allow_stat;
    afd_pkg::list_stat_t          deny_stat;
    logic                         res_success;
    logic [afd_pkg::STAT_W-1:0]   res_status;
    logic                         res_allowed;
    logic                         res_in_deny;
    logic                         res_in_allow;
    logic                         sel_full;
    logic                         sel_found;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign upd_go   = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == CNT_W'(MAX_ENTRIES - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + CNT_W'(1);
            end
            else
            begin
                sweep_cnt_reg <= '0;
            end
            if (upd_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tdata[1:0];
            addr_reg <= s_tdata[49:2];
            sel_reg  <= s_tuser;
        end
        if (upd_go)
        begin
            out_data_reg <= {deny_stat.count_next, allow_stat.count_next, res_in_allow,
                             res_in_deny, res_allowed, res_status, res_success};
        end
    end

    assign allow_ctrl.compare = (state_reg == ST_COMPARE);
    assign allow_ctrl.sweep   = (state_reg == ST_SWEEP);
    assign allow_ctrl.add     = upd_go && (op_reg == afd_pkg::OP_ADD)
                                && (sel_reg == afd_pkg::LIST_ALLOW);
    assign allow_ctrl.remove  = upd_go && (op_reg == afd_pkg::OP_REMOVE);

    assign deny_ctrl.compare  = (state_reg == ST_COMPARE);
    assign deny_ctrl.sweep    = (state_reg == ST_SWEEP);
    assign deny_ctrl.add      = upd_go && (op_reg == afd_pkg::OP_ADD)
                                && (sel_reg == afd_pkg::LIST_DENY);
    assign deny_ctrl.remove   = upd_go && (op_reg == afd_pkg::OP_REMOVE);

    afd_list #(.MAX_ENTRIES(MAX_ENTRIES)) u_allow_list
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (allow_ctrl),
        .addr  (addr_reg),
        .stat  (allow_stat)
    );

    afd_list #(.MAX_ENTRIES(MAX_ENTRIES)) u_deny_list
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (deny_ctrl),
        .addr  (addr_reg),
        .stat  (deny_stat)
    );

    assign sel_full  = (sel_reg == afd_pkg::LIST_DENY) ? deny_stat.full : allow_stat.full;
    assign sel_found = (sel_reg == afd_pkg::LIST_DENY) ? deny_stat.found : allow_stat.found;

    always_comb
    begin
        res_in_allow = allow_stat.found;
        res_in_deny  = deny_stat.found;
        res_status   = afd_pkg::STATUS_DONE;
        res_success  = 1'b0;
        unique case (op_reg)
            afd_pkg::OP_ADD:
            begin
                if (sel_full)
                begin
                    res_status = afd_pkg::STATUS_FULL;
                end
                else
                begin
                    res_success = 1'b1;
                    if (sel_found)
                    begin
                        res_status = afd_pkg::STATUS_PRESENT;
                    end
                    if (sel_reg == afd_pkg::LIST_DENY)
                    begin
                        res_in_deny = 1'b1;
                    end
                    else
                    begin
                        res_in_allow = 1'b1;
                    end
                end
            end
            afd_pkg::OP_REMOVE:
            begin
                res_in_allow = 1'b0;
                res_in_deny  = 1'b0;
                res_success  = allow_stat.found || deny_stat.found;
                if (!res_success)
                begin
                    res_status = afd_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                res_success = !res_in_deny && (allow_stat.empty_next || res_in_allow);
            end
        endcase
    end

    assign res_allowed = !res_in_deny && (allow_stat.empty_next || res_in_allow);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_UPDATE))
        else $error("A result appeared without an update cycle.");

    a_allowed_not_denied: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("A denied address was reported as allowed.");

    a_full_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:1] == afd_pkg::STATUS_FULL)) |-> !m_tdata[0])
        else $error("An add to a full list reported success.");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("A new item was taken while one is in progress.");
`endif

endmodule

### bench/address_allow_deny_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_allow_deny_filter_core_tb: self-checking bench for the allow/deny filter
// Sends queries, adds and removes over the input stream and predicts every
// result from a behavioral copy of both address lists. Each output transfer
// is compared field by field with the oldest prediction. A directed table
// covers empty lists, duplicates, overlap of both lists and a full list. It
// is followed by random operations on a small address pool, so the lists
// fill, overflow and drain. Both stream sides idle in random bursts, and
// the output side holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module address_allow_deny_filter_core_tb;

    localparam int MAX_ENTRIES  = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_SIZE    = 24;
    localparam int STALL_LIMIT  = 3000;

    localparam logic [afd_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef logic [afd_pkg::ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [afd_pkg::COUNT_W-1:0] deny_count;
        logic [afd_pkg::COUNT_W-1:0] allow_count;
        logic                        in_allow;
        logic                        in_deny;
        logic                        allowed;
        logic [afd_pkg::STAT_W-1:0]  status;
        logic                        success;
    } filter_result_t;

    typedef struct {
        logic [afd_pkg::OP_W-1:0] op;
        addr_t                    addr;
        logic                     sel;
        bit                       fixed;
        filter_result_t           want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    addr_t          lists [2][MAX_ENTRIES];
    int             list_len [2] = '{0, 0};
    filter_result_t pending [$];
    stim_row_t      stim_rows [$];
    addr_t          pool [POOL_SIZE];
    int             errors = 0;
    int             idle_cycles = 0;
    bit             hold_output = 1'b0;
    bit             quiet = 1'b0;
    bit             sender_idles = 1'b1;
    bit             receiver_idles = 1'b1;

    address_allow_deny_filter_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic addr_t random_addr();
        return addr_t'({$urandom, $urandom});
    endfunction

    function automatic filter_result_t outcome(logic success,
                                               logic [afd_pkg::STAT_W-1:0] status,
                                               logic allowed, logic in_deny, logic in_allow,
                                               int allow_count, int deny_count);
        filter_result_t r;
        r.success     = success;
        r.status      = status;
        r.allowed     = allowed;
        r.in_deny     = in_deny;
        r.in_allow    = in_allow;
        r.allow_count = afd_pkg::COUNT_W'(allow_count);
        r.deny_count  = afd_pkg::COUNT_W'(deny_count);
        return r;
    endfunction

    function automatic int locate(logic which, addr_t addr);
        for (int i = 0; i < list_len[which]; i++)
        begin
            if (lists[which][i] == addr)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit drop(logic which, addr_t addr);
        int pos;
        pos = locate(which, addr);
        if (pos < 0)
        begin
            return 1'b0;
        end
        for (int i = pos; i < list_len[which] - 1; i++)
        begin
            lists[which][i] = lists[which][i + 1];
        end
        list_len[which]--;
        return 1'b1;
    endfunction

    function automatic filter_result_t predict_filter(logic [afd_pkg::OP_W-1:0] op,
                                                      addr_t addr, logic sel);
        filter_result_t r;
        bit             from_allow;
        bit             from_deny;
        r = '0;
        if (op == afd_pkg::OP_ADD)
        begin
            if (list_len[sel] >= MAX_ENTRIES)
            begin
                r.status = afd_pkg::STATUS_FULL;
            end
            else if (locate(sel, addr) >= 0)
            begin
                r.status = afd_pkg::STATUS_PRESENT;
            end
            else
            begin
                lists[sel][list_len[sel]] = addr;
                list_len[sel]++;
                r.status = afd_pkg::STATUS_DONE;
            end
            r.success = (r.status != afd_pkg::STATUS_FULL);
        end
        else if (op == afd_pkg::OP_REMOVE)
        begin
            from_allow = drop(afd_pkg::LIST_ALLOW, addr);
            from_deny  = drop(afd_pkg::LIST_DENY, addr);
            r.success  = from_allow || from_deny;
            r.status   = r.success ? afd_pkg::STATUS_DONE : afd_pkg::STATUS_NOT_FOUND;
        end
        r.in_deny  = (locate(afd_pkg::LIST_DENY, addr) >= 0);
        r.in_allow = (locate(afd_pkg::LIST_ALLOW, addr) >= 0);
        r.allowed  = !r.in_deny && (list_len[afd_pkg::LIST_ALLOW] == 0 || r.in_allow);
        if (op == afd_pkg::OP_QUERY || op == OP_SPARE)
        begin
            r.success = r.allowed;
            r.status  = afd_pkg::STATUS_DONE;
        end
        r.allow_count = afd_pkg::COUNT_W'(list_len[afd_pkg::LIST_ALLOW]);
        r.deny_count  = afd_pkg::COUNT_W'(list_len[afd_pkg::LIST_DENY]);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    task automatic add_row(input logic [afd_pkg::OP_W-1:0] op, input addr_t addr,
                           input logic sel, input bit fixed, input filter_result_t want);
        stim_row_t row;
        row.op    = op;
        row.addr  = addr;
        row.sel   = sel;
        row.fixed = fixed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    task automatic send_request(input logic [afd_pkg::OP_W-1:0] op, input addr_t addr,
                                input logic sel, input bit fixed,
                                input filter_result_t want);
        filter_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, addr, op};
        s_tuser  <= sel;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_filter(op, addr, sel);
        pending.push_back(fixed ? want : predicted);
        @(negedge clk);
        if (sender_idles && !quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    initial
    begin
        addr_t                    ones;
        addr_t                    addr;
        logic [afd_pkg::OP_W-1:0] op;
        int                       pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        ones     = '1;

        add_row(afd_pkg::OP_QUERY, '0, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0, 0, 0));
        add_row(afd_pkg::OP_QUERY, ones, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0, 0, 0));
        add_row(OP_SPARE, 48'h5555_5555_5555, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0, 0, 0));
        add_row(afd_pkg::OP_REMOVE, ones, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b0, afd_pkg::STATUS_NOT_FOUND, 1'b1, 1'b0, 1'b0, 0, 0));
        add_row(afd_pkg::OP_ADD, '0, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b1, 1, 0));
        add_row(afd_pkg::OP_ADD, '0, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_PRESENT, 1'b1, 1'b0, 1'b1, 1, 0));
        add_row(afd_pkg::OP_QUERY, ones, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b0, afd_pkg::STATUS_DONE, 1'b0, 1'b0, 1'b0, 1, 0));
        add_row(afd_pkg::OP_ADD, ones, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b0, 1'b1, 1'b0, 1, 1));
        add_row(afd_pkg::OP_ADD, '0, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b0, 1'b1, 1'b1, 1, 2));
        add_row(afd_pkg::OP_QUERY, '0, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b0, afd_pkg::STATUS_DONE, 1'b0, 1'b1, 1'b1, 1, 2));
        add_row(afd_pkg::OP_REMOVE, '0, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0, 0, 1));
        for (int i = 1; i < MAX_ENTRIES; i++)
        begin
            add_row(afd_pkg::OP_ADD, random_addr(), afd_pkg::LIST_DENY, 1'b0, '0);
        end
        add_row(afd_pkg::OP_ADD, ones, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b0, afd_pkg::STATUS_FULL, 1'b0, 1'b1, 1'b0, 0, MAX_ENTRIES));
        add_row(afd_pkg::OP_ADD, 48'h0123_4567_89AB, afd_pkg::LIST_DENY, 1'b1,
                outcome(1'b0, afd_pkg::STATUS_FULL, 1'b1, 1'b0, 1'b0, 0, MAX_ENTRIES));
        add_row(afd_pkg::OP_REMOVE, ones, afd_pkg::LIST_ALLOW, 1'b1,
                outcome(1'b1, afd_pkg::STATUS_DONE, 1'b1, 1'b0, 1'b0, 0, MAX_ENTRIES - 1));

        pool[0] = '0;
        pool[1] = ones;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            pool[i] = random_addr();
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            send_request(stim_rows[i].op, stim_rows[i].addr, stim_rows[i].sel,
                         stim_rows[i].fixed, stim_rows[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            if (n == HOLD_AT_ITEM)
            begin
                hold_output = 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
            begin
                sender_idles = !sender_idles;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                pool[$urandom_range(2, POOL_SIZE - 1)] = random_addr();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                op = afd_pkg::OP_ADD;
            end
            else if (pick < 60)
            begin
                op = afd_pkg::OP_REMOVE;
            end
            else if (pick < 95)
            begin
                op = afd_pkg::OP_QUERY;
            end
            else
            begin
                op = OP_SPARE;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                addr = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else
            begin
                addr = random_addr();
            end
            send_request(op, addr, 1'($urandom_range(0, 1)), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_ENTRIES + 8) @(posedge clk);
        if (errors == 0)
        begin
            $display("address_allow_deny_filter_core_tb OK");
        end
        else
        begin
            $display("address_allow_deny_filter_core_tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
            begin
                receiver_idles = !receiver_idles;
            end
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                m_tready <= 1'b1;
            end
            else if (receiver_idles && !quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        filter_result_t got;
        filter_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("result transfer %h with no request outstanding",
                                          m_tdata));
            end
            else
            begin
                want = pending.pop_front();
                if (got.success !== want.success)
                begin
                    report_mismatch($sformatf("success got %0d, expected %0d",
                                              got.success, want.success));
                end
                if (got.status !== want.status)
                begin
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              got.status, want.status));
                end
                if (got.allowed !== want.allowed)
                begin
                    report_mismatch($sformatf("allowed got %0d, expected %0d",
                                              got.allowed, want.allowed));
                end
                if (got.in_deny !== want.in_deny)
                begin
                    report_mismatch($sformatf("in_deny_list got %0d, expected %0d",
                                              got.in_deny, want.in_deny));
                end
                if (got.in_allow !== want.in_allow)
                begin
                    report_mismatch($sformatf("in_allow_list got %0d, expected %0d",
                                              got.in_allow, want.in_allow));
                end
                if (got.allow_count !== want.allow_count)
                begin
                    report_mismatch($sformatf("allow_count got %0d, expected %0d",
                                              got.allow_count, want.allow_count));
                end
                if (got.deny_count !== want.deny_count)
                begin
                    report_mismatch($sformatf("deny_count got %0d, expected %0d",
                                              got.deny_count, want.deny_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("address_allow_deny_filter_core_tb NOT OK");
                $finish;
            end
        end
    end

endmodule
